// ===== hw/rtl/pmrf_pkg.sv =====
// ----------------------------------------------------------------------------
// pmrf_pkg
// Shared types and constants of the power monitor response framer.
// ----------------------------------------------------------------------------
package pmrf_pkg;

	localparam int MaxFrameDefault = 128;

	// Header codes seen while hunting
	localparam logic [7:0] HdrAck    = 8'h06;
	localparam logic [7:0] HdrNack   = 8'h15;
	localparam logic [7:0] HdrCsFail = 8'h51;

	// Shortest legal frame: header, length, checksum
	localparam logic [7:0] MinFrameLen = 8'd3;

	// Frame byte positions of the captured fields
	localparam logic [7:0] PosVoltLo = 8'd2;
	localparam logic [7:0] PosVoltHi = 8'd3;
	localparam logic [7:0] PosCurr0  = 8'd10;
	localparam logic [7:0] PosCurr1  = 8'd11;
	localparam logic [7:0] PosCurr2  = 8'd12;
	localparam logic [7:0] PosCurr3  = 8'd13;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SUM_BAD    = 3'd1,
		ST_NACK       = 3'd2,
		ST_DEV_CSFAIL = 3'd3,
		ST_UNKNOWN    = 3'd4,
		ST_BAD_LEN    = 3'd5
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] voltage_raw;
		logic [31:0] current_raw;
	} result_t;

endpackage

// ===== hw/rtl/pmrf_in_if.sv =====
// ----------------------------------------------------------------------------
// pmrf_in_if
// Received byte channel: valid/ready handshake with one byte per word.
// ----------------------------------------------------------------------------
interface pmrf_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== hw/rtl/pmrf_out_if.sv =====
// ----------------------------------------------------------------------------
// pmrf_out_if
// Result channel: valid/ready handshake with status, voltage and current.
// ----------------------------------------------------------------------------
interface pmrf_out_if;

	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] voltage_raw;
	logic [31:0] current_raw;

	modport source (output valid, output status, output voltage_raw, output current_raw,
		input ready);
	modport sink   (input valid, input status, input voltage_raw, input current_raw,
		output ready);

endinterface

// ===== hw/rtl/pmrf_parser.sv =====
// ----------------------------------------------------------------------------
// pmrf_parser
// Frame state and per-byte decision: header decode, length check, checksum
// accumulation and field capture.
// ----------------------------------------------------------------------------
module pmrf_parser
	import pmrf_pkg::*;
#(
	parameter int MAX_FRAME = MaxFrameDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] rx_byte,
	output logic       emit,
	output result_t    result
);

	localparam logic [7:0] MaxLen = 8'(MAX_FRAME);

	logic        in_frame_q, in_frame_d;
	logic [7:0]  idx_q, idx_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] volt_q, volt_d;
	logic [31:0] curr_q, curr_d;
	logic [8:0]  idx_next;

	assign idx_next = {1'b0, idx_q} + 9'd1;

	always_comb begin
		in_frame_d = in_frame_q;
		idx_d      = idx_q;
		len_d      = len_q;
		sum_d      = sum_q;
		volt_d     = volt_q;
		curr_d     = curr_q;
		emit       = 1'b0;
		result     = '{status: ST_UNKNOWN, voltage_raw: '0, current_raw: '0};
		if (!in_frame_q) begin
			if (rx_byte == HdrAck) begin
				in_frame_d = 1'b1;
				idx_d      = 8'd1;
				len_d      = '0;
				sum_d      = rx_byte;
				volt_d     = '0;
				curr_d     = '0;
			end else begin
				emit = 1'b1;
				if (rx_byte == HdrNack)
					result.status = ST_NACK;
				else if (rx_byte == HdrCsFail)
					result.status = ST_DEV_CSFAIL;
			end
		end else if (idx_q <= 8'd1) begin
			// length byte
			if (rx_byte < MinFrameLen || rx_byte > MaxLen) begin
				emit          = 1'b1;
				result.status = ST_BAD_LEN;
				in_frame_d    = 1'b0;
				idx_d         = '0;
				sum_d         = '0;
			end else begin
				len_d = rx_byte;
				sum_d = sum_q + rx_byte;
				idx_d = 8'd2;
			end
		end else if (idx_next >= {1'b0, len_q}) begin
			// checksum byte closes the frame
			emit       = 1'b1;
			in_frame_d = 1'b0;
			idx_d      = '0;
			sum_d      = '0;
			if (rx_byte == sum_q) begin
				result.status      = ST_OK;
				result.voltage_raw = volt_q;
				result.current_raw = curr_q;
			end else begin
				result.status = ST_SUM_BAD;
			end
		end else begin
			sum_d = sum_q + rx_byte;
			idx_d = idx_next[7:0];
			case (idx_q)
				PosVoltLo: volt_d[7:0]   = rx_byte;
				PosVoltHi: volt_d[15:8]  = rx_byte;
				PosCurr0:  curr_d[7:0]   = rx_byte;
				PosCurr1:  curr_d[15:8]  = rx_byte;
				PosCurr2:  curr_d[23:16] = rx_byte;
				PosCurr3:  curr_d[31:24] = rx_byte;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			idx_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
		end else if (adv) begin
			in_frame_q <= in_frame_d;
			idx_q      <= idx_d;
			len_q      <= len_d;
			sum_q      <= sum_d;
		end
	end

	// captures are cleared whenever a frame opens
	always_ff @(posedge clk) begin
		if (adv) begin
			volt_q <= volt_d;
			curr_q <= curr_d;
		end
	end

endmodule

// ===== hw/rtl/pmrf_out_buf.sv =====
// ----------------------------------------------------------------------------
// pmrf_out_buf
// Result register with a skid entry, so upstream ready is registered.
// ----------------------------------------------------------------------------
module pmrf_out_buf
	import pmrf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  result_t             push_data,
	output logic                space,
	pmrf_out_if.source          out_ch
);

	logic    valid_q;
	logic    skid_valid_q;
	result_t data_q;
	result_t skid_q;
	logic    pop;

	assign pop   = valid_q && out_ch.ready;
	assign space = !skid_valid_q;

	assign out_ch.valid       = valid_q;
	assign out_ch.status      = data_q.status;
	assign out_ch.voltage_raw = data_q.voltage_raw;
	assign out_ch.current_raw = data_q.current_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else if (!push)
				valid_q <= 1'b0;
		end else if (push) begin
			if (!valid_q)
				valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				data_q <= skid_q;
			else if (push)
				data_q <= push_data;
		end else if (push) begin
			if (!valid_q)
				data_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

endmodule

// ===== hw/rtl/power_monitor_response_framer_unit.sv =====
// ----------------------------------------------------------------------------
// power_monitor_response_framer_unit
// Parses power monitor response frames from a received byte stream.
// ----------------------------------------------------------------------------
// The unit takes one received byte per word on rx and produces zero or one
// result per byte on resp. While hunting, NACK, device checksum fail and
// unknown header bytes each give a status word; an ACK opens a frame whose
// next byte is the total length (header and checksum included, 3 to
// MAX_FRAME, otherwise a bad length status). Frame bytes are summed modulo
// 256 and the last byte is checked against that sum; a good frame reports
// voltage (bytes 2-3) and current (bytes 10-13), little-endian, and every
// other status carries zero fields. Throughput is one byte per clock while
// the result buffer has room: a byte is held in the input register while the
// parser updates its small register set with one add and compare and writes
// the result register. A result, if any, comes from the byte in the input
// register and is held in the result register; a two-entry result buffer keeps
// rx ready registered, so rx keeps flowing while one result waits on resp.
// ----------------------------------------------------------------------------
module power_monitor_response_framer_unit
	import pmrf_pkg::*;
#(
	parameter int MAX_FRAME = MaxFrameDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	pmrf_in_if.sink     rx,
	pmrf_out_if.source  resp
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       space;
	logic       adv;
	logic       emit;
	result_t    result;

	// advance the held byte when the result buffer has room
	assign adv      = valid_s1 && space;
	assign rx.ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// hold the byte until it is consumed
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	pmrf_parser #(
		.MAX_FRAME(MAX_FRAME)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.rx_byte(byte_s1),
		.emit   (emit),
		.result (result)
	);

	pmrf_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv && emit),
		.push_data(result),
		.space    (space),
		.out_ch   (resp)
	);

endmodule
